// File: rtl/core/nv21_to_argb_converter_unit_macros.svh
// Assertion macros shared by the NV21 to ARGB converter RTL.
`ifndef NV21_TO_ARGB_CONVERTER_UNIT_MACROS_SVH
`define NV21_TO_ARGB_CONVERTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check prop at every clock edge outside reset.
`define NV2A_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nv2a assertion failed");
// Check that cond never holds outside reset.
`define NV2A_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nv2a forbidden condition seen");
`else
`define NV2A_ASSERT(lbl, clk, rst_n, prop)
`define NV2A_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/nv2a_pkg.sv
// Shared types, constants and helpers of the NV21 to ARGB converter.
package nv2a_pkg;

    localparam int LINE_WIDTH_W = 13;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd640;

    localparam int PIX_W  = 8;
    localparam int ARGB_W = 32;

    localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0] CHROMA_RESET  = 8'd128;
    localparam logic [PIX_W-1:0] ALPHA_OPAQUE  = 8'hFF;

    // Signed width that holds every product and every sum of the color math.
    localparam int SUM_W     = 21;
    localparam int FRAC_BITS = 10;

    localparam logic signed [SUM_W-1:0] COEF_Y    = 21'sd1192;
    localparam logic signed [SUM_W-1:0] COEF_RV   = 21'sd1634;
    localparam logic signed [SUM_W-1:0] COEF_GV   = 21'sd833;
    localparam logic signed [SUM_W-1:0] COEF_GU   = 21'sd400;
    localparam logic signed [SUM_W-1:0] COEF_BU   = 21'sd2066;
    localparam logic signed [SUM_W-1:0] CLAMP_MAX = 21'sd262143;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // One classified pixel: offset luma and centered chroma.
    typedef struct packed {
        logic [PIX_W-1:0]        y;
        logic signed [PIX_W-1:0] v;
        logic signed [PIX_W-1:0] u;
    } t_mid;

    localparam int MID_W = $bits(t_mid);

    // Clamp to 0..262143 and keep the top byte of the 18-bit range.
    function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] x);
        logic [PIX_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > CLAMP_MAX) begin
            res = '1;
        end else begin
            res = x[FRAC_BITS +: PIX_W];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/nv2a_fifo.sv
// Small first-in first-out queue built from flip-flops.
module nv2a_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full    = (r_count == CW'(DEPTH));
        o_empty   = (r_count == '0);
        o_count   = r_count;
        o_rd_data = r_mem[r_rd_ptr];
        do_push   = i_push && !o_full;
        do_pop    = i_pop && !o_empty;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_count   = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: rtl/core/nv2a_front.sv
// Front end: accept pixels, track column parity, latch chroma, classify.
`include "nv21_to_argb_converter_unit_macros.svh"

module nv2a_front #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [nv2a_pkg::LINE_WIDTH_W-1:0]  i_cfg_wr_data,
    input  logic                               i_push,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_luma,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_chroma_v,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_chroma_u,
    output logic                               o_full,
    input  logic                               i_mid_full,
    output logic                               o_mid_push,
    output nv2a_pkg::t_mid                     o_mid_data
);

    localparam int CW   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int NW   = CW + 1;
    localparam int LW   = nv2a_pkg::LINE_WIDTH_W;
    localparam int CMPW = (NW > LW) ? NW : LW;
    localparam int PW   = nv2a_pkg::PIX_W;

    logic [LW-1:0] r_line_width, n_line_width;
    logic [CW-1:0] r_col, n_col;
    logic [PW-1:0] r_held_v, n_held_v;
    logic [PW-1:0] r_held_u, n_held_u;
    logic          accept;
    logic          even_col;
    logic          wrap;
    logic [NW-1:0] col_inc;
    logic [PW-1:0] v_sel;
    logic [PW-1:0] u_sel;

    always_comb begin
        accept   = i_push && !i_mid_full;
        even_col = !r_col[0];
        v_sel    = even_col ? i_chroma_v : r_held_v;
        u_sel    = even_col ? i_chroma_u : r_held_u;
        col_inc  = NW'(r_col) + NW'(1);
        // Width zero acts as one and widths past the maximum saturate.
        wrap     = (CMPW'(col_inc) >= CMPW'(r_line_width))
                || (col_inc >= NW'(MAX_LINE_WIDTH));

        n_line_width = i_cfg_wr_en ? i_cfg_wr_data : r_line_width;
        n_col        = r_col;
        n_held_v     = r_held_v;
        n_held_u     = r_held_u;
        if (accept) begin
            n_col    = wrap ? '0 : col_inc[CW-1:0];
            n_held_v = v_sel;
            n_held_u = u_sel;
        end

        o_full            = i_mid_full;
        o_mid_push        = accept;
        o_mid_data.y      = (i_luma < nv2a_pkg::LUMA_OFFSET) ? '0
                          : i_luma - nv2a_pkg::LUMA_OFFSET;
        o_mid_data.v      = signed'({~v_sel[PW-1], v_sel[PW-2:0]});
        o_mid_data.u      = signed'({~u_sel[PW-1], u_sel[PW-2:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= nv2a_pkg::LINE_WIDTH_RESET;
            r_col        <= '0;
            r_held_v     <= nv2a_pkg::CHROMA_RESET;
            r_held_u     <= nv2a_pkg::CHROMA_RESET;
        end else begin
            r_line_width <= n_line_width;
            r_col        <= n_col;
            r_held_v     <= n_held_v;
            r_held_u     <= n_held_u;
        end
    end

    `NV2A_ASSERT(a_col_in_range, i_clk, i_rst_n, NW'(r_col) < NW'(MAX_LINE_WIDTH))
    `NV2A_ASSERT(a_even_latches, i_clk, i_rst_n,
                 (accept && even_col) |=> ((r_held_v == $past(i_chroma_v))
                                           && (r_held_u == $past(i_chroma_u))))
    `NV2A_ASSERT(a_odd_holds, i_clk, i_rst_n,
                 (accept && !even_col) |=> ($stable(r_held_v) && $stable(r_held_u)))

endmodule

// File: rtl/core/nv2a_back.sv
// Back end: color math with registered coefficient products feeding the result queue.
`include "nv21_to_argb_converter_unit_macros.svh"

module nv2a_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mid_empty,
    input  nv2a_pkg::t_mid              i_mid_data,
    output logic                        o_mid_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [nv2a_pkg::ARGB_W-1:0] o_argb_pixel
);

    localparam int SW  = nv2a_pkg::SUM_W;
    localparam int PW  = nv2a_pkg::PIX_W;
    localparam int OD  = nv2a_pkg::OUT_DEPTH;
    localparam int OCW = $clog2(OD + 1);

    logic                   r_s1_valid, n_s1_valid;
    logic signed [SW-1:0]   r_y_term, r_rv_term, r_gv_term, r_gu_term, r_bu_term;
    logic signed [SW-1:0]   y_ext, v_ext, u_ext;
    logic signed [SW-1:0]   red_sum, g_sum, b_sum;
    logic [nv2a_pkg::ARGB_W-1:0] pixel;
    logic [OCW-1:0]         out_count;
    logic                   out_full;

    always_comb begin
        // Pull a pixel only when the result queue has room for everything in flight.
        o_mid_pop  = !i_mid_empty
                   && ((OCW + 1)'(out_count) + (OCW + 1)'(r_s1_valid) < (OCW + 1)'(OD));
        n_s1_valid = o_mid_pop;
        y_ext      = SW'(signed'({1'b0, i_mid_data.y}));
        v_ext      = SW'(i_mid_data.v);
        u_ext      = SW'(i_mid_data.u);

        red_sum = r_y_term + r_rv_term;
        g_sum   = r_y_term - r_gv_term - r_gu_term;
        b_sum   = r_y_term + r_bu_term;
        pixel   = {nv2a_pkg::ALPHA_OPAQUE,
                   nv2a_pkg::clamp_byte(red_sum),
                   nv2a_pkg::clamp_byte(g_sum),
                   nv2a_pkg::clamp_byte(b_sum)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_y_term  <= y_ext * nv2a_pkg::COEF_Y;
            r_rv_term <= v_ext * nv2a_pkg::COEF_RV;
            r_gv_term <= v_ext * nv2a_pkg::COEF_GV;
            r_gu_term <= u_ext * nv2a_pkg::COEF_GU;
            r_bu_term <= u_ext * nv2a_pkg::COEF_BU;
        end
    end

    nv2a_fifo #(
        .WIDTH (nv2a_pkg::ARGB_W),
        .DEPTH (OD)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (r_s1_valid),
        .i_wr_data (pixel),
        .i_pop     (i_pop),
        .o_rd_data (o_argb_pixel),
        .o_full    (out_full),
        .o_empty   (o_empty),
        .o_count   (out_count)
    );

    `NV2A_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, r_s1_valid && out_full)
    `NV2A_ASSERT(a_credit, i_clk, i_rst_n,
                 (OCW + 1)'(out_count) + (OCW + 1)'(r_s1_valid) <= (OCW + 1)'(OD))
    `NV2A_ASSERT(a_result_lands, i_clk, i_rst_n, r_s1_valid |=> !o_empty)

endmodule

// File: rtl/core/nv21_to_argb_converter_unit.sv
// NV21 pixel stream to opaque ARGB8888 converter, top level.
// A pixel passes through the classify queue, the product registers and the result queue.
// Throughput: one pixel per clock, sustained while results are popped every cycle.
// The rate is set by the two-entry classify queue and the four-entry result queue.
// Reset (synchronous, active low): line width 640, column 0, chroma pair 128/128.
// Reset also empties both queues; no clearing pass is needed.
`include "nv21_to_argb_converter_unit_macros.svh"

module nv21_to_argb_converter_unit #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: line width, written whenever the enable is high.
    input  logic                               i_cfg_wr_en,
    input  logic [nv2a_pkg::LINE_WIDTH_W-1:0]  i_cfg_wr_data,
    // Pixel input side, queue style.
    input  logic                               push,
    output logic                               full,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_luma,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_chroma_v,
    input  logic [nv2a_pkg::PIX_W-1:0]         i_chroma_u,
    // Result side, queue style.
    output logic                               empty,
    input  logic                               pop,
    output logic [nv2a_pkg::ARGB_W-1:0]        o_argb_pixel
);

    // The front end owns the column counter and the held chroma pair; it
    // turns each pixel into offset luma plus centered chroma. Every input
    // beat yields exactly one classified beat, so the front never stalls
    // except on a full classify queue.
    logic                       mid_push;
    logic                       mid_pop;
    logic                       mid_full;
    logic                       mid_empty;
    nv2a_pkg::t_mid             mid_wr_data;
    logic [nv2a_pkg::MID_W-1:0] mid_rd_data;
    logic [$clog2(nv2a_pkg::MID_DEPTH + 1)-1:0] mid_count;

    nv2a_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (push),
        .i_luma        (i_luma),
        .i_chroma_v    (i_chroma_v),
        .i_chroma_u    (i_chroma_u),
        .o_full        (full),
        .i_mid_full    (mid_full),
        .o_mid_push    (mid_push),
        .o_mid_data    (mid_wr_data)
    );

    // Decouple the two halves: the front keeps taking pixels while the
    // back waits on a full result queue, and the reverse.
    nv2a_fifo #(
        .WIDTH (nv2a_pkg::MID_W),
        .DEPTH (nv2a_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (mid_push),
        .i_wr_data (mid_wr_data),
        .i_pop     (mid_pop),
        .o_rd_data (mid_rd_data),
        .o_full    (mid_full),
        .o_empty   (mid_empty),
        .o_count   (mid_count)
    );

    // The back end registers the five coefficient products, then adds,
    // clamps and packs straight into its result queue. It pulls a beat
    // only when the result queue is sure to have room for it.
    nv2a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mid_empty  (mid_empty),
        .i_mid_data   (mid_rd_data),
        .o_mid_pop    (mid_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_argb_pixel (o_argb_pixel)
    );

    `NV2A_ASSERT(a_mid_count_ok, i_clk, i_rst_n, (mid_count == '0) == mid_empty)
    `NV2A_ASSERT(a_mid_push_room, i_clk, i_rst_n,
                 (mid_full && !mid_pop) |=> (mid_count == $past(mid_count)))
    `NV2A_ASSERT(a_pull_fills, i_clk, i_rst_n,
                 (mid_pop && !mid_push) |=> (mid_count == $past(mid_count) - 1'b1))

endmodule

// File: test/nv21_to_argb_converter_unit_tb.sv
// Self-checking testbench of the NV21 to ARGB8888 pixel converter.
module nv21_to_argb_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH   = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int REPORT_MAX  = 10;

    // One directed beat: the pixel bytes and, where it is obvious, the pixel it must give.
    typedef struct packed {
        logic [nv2a_pkg::PIX_W-1:0]  luma;
        logic [nv2a_pkg::PIX_W-1:0]  chroma_v;
        logic [nv2a_pkg::PIX_W-1:0]  chroma_u;
        logic                        known;
        logic [nv2a_pkg::ARGB_W-1:0] argb;
    } t_stim_row;

    // Rows start at column 0 with the reset line width, so even rows latch chroma
    // and odd rows reuse it.
    localparam int DIRECTED_COUNT = 24;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'd16,  8'd128, 8'd128, 1'b1, 32'hFF000000},  // black with the reset chroma
        '{8'd255, 8'd0,   8'd0,   1'b1, 32'hFFFFFFFF},  // odd column: chroma bytes ignored
        '{8'd0,   8'd128, 8'd128, 1'b1, 32'hFF000000},  // luma under 16 clamps to black
        '{8'd255, 8'd255, 8'd255, 1'b1, 32'hFFFFFFFF},  // saturated white, chroma ignored
        '{8'd255, 8'd255, 8'd255, 1'b0, 32'h0},
        '{8'd0,   8'd0,   8'd0,   1'b0, 32'h0},
        '{8'd0,   8'd0,   8'd0,   1'b0, 32'h0},
        '{8'd255, 8'd128, 8'd128, 1'b0, 32'h0},
        '{8'd15,  8'd255, 8'd0,   1'b0, 32'h0},
        '{8'd17,  8'd0,   8'd255, 1'b0, 32'h0},
        '{8'd128, 8'd0,   8'd255, 1'b0, 32'h0},
        '{8'd128, 8'd255, 8'd0,   1'b0, 32'h0},
        '{8'd235, 8'd240, 8'd16,  1'b0, 32'h0},
        '{8'd81,  8'd90,  8'd240, 1'b0, 32'h0},
        '{8'd145, 8'd54,  8'd34,  1'b0, 32'h0},
        '{8'd41,  8'd110, 8'd240, 1'b0, 32'h0},
        '{8'd1,   8'd1,   8'd1,   1'b0, 32'h0},
        '{8'd254, 8'd254, 8'd254, 1'b0, 32'h0},
        '{8'd16,  8'd127, 8'd129, 1'b0, 32'h0},
        '{8'd16,  8'd129, 8'd127, 1'b0, 32'h0},
        '{8'd200, 8'd128, 8'd255, 1'b0, 32'h0},
        '{8'd200, 8'd128, 8'd0,   1'b0, 32'h0},
        '{8'd100, 8'd255, 8'd128, 1'b0, 32'h0},
        '{8'd100, 8'd0,   8'd128, 1'b0, 32'h0}
    };

    // DUT ports; every input starts at a known value.
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_wr_en   = 1'b0;
    logic [nv2a_pkg::LINE_WIDTH_W-1:0] i_cfg_wr_data = '0;
    logic                              push          = 1'b0;
    logic                              full;
    logic [nv2a_pkg::PIX_W-1:0]        i_luma        = '0;
    logic [nv2a_pkg::PIX_W-1:0]        i_chroma_v    = '0;
    logic [nv2a_pkg::PIX_W-1:0]        i_chroma_u    = '0;
    logic                              empty;
    logic                              pop           = 1'b0;
    logic [nv2a_pkg::ARGB_W-1:0]       o_argb_pixel;

    // Converter state as the testbench tracks it.
    logic [nv2a_pkg::LINE_WIDTH_W-1:0] model_line_width = nv2a_pkg::LINE_WIDTH_RESET;
    int unsigned                       model_column     = 0;
    logic [nv2a_pkg::PIX_W-1:0]        model_held_v     = nv2a_pkg::CHROMA_RESET;
    logic [nv2a_pkg::PIX_W-1:0]        model_held_u     = nv2a_pkg::CHROMA_RESET;

    logic [nv2a_pkg::ARGB_W-1:0] expected_pixels [$];
    int unsigned                 mismatch_count = 0;
    int unsigned                 cycle_count    = 0;
    int unsigned                 pop_hold       = 0;
    logic                        quiet_phase    = 1'b0;

    nv21_to_argb_converter_unit #(
        .MAX_LINE_WIDTH(MAX_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_luma        (i_luma),
        .i_chroma_v    (i_chroma_v),
        .i_chroma_u    (i_chroma_u),
        .empty         (empty),
        .pop           (pop),
        .o_argb_pixel  (o_argb_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp a channel sum to the 18-bit range.
    function automatic int clamp_channel(input int x);
        if (x < 0) begin
            return 0;
        end
        if (x > 262143) begin
            return 262143;
        end
        return x;
    endfunction

    // Color math of one pixel from its luma and the chroma pair in force.
    function automatic logic [nv2a_pkg::ARGB_W-1:0] yuv_to_argb(
        input logic [nv2a_pkg::PIX_W-1:0] luma,
        input logic [nv2a_pkg::PIX_W-1:0] cv,
        input logic [nv2a_pkg::PIX_W-1:0] cu);
        int y;
        int v;
        int u;
        int y_term;
        int r;
        int g;
        int b;
        y = luma;
        y = y - 16;
        if (y < 0) begin
            y = 0;
        end
        v = cv;
        v = v - 128;
        u = cu;
        u = u - 128;
        y_term = 1192 * y;
        r = clamp_channel(y_term + 1634 * v);
        g = clamp_channel(y_term - 833 * v - 400 * u);
        b = clamp_channel(y_term + 2066 * u);
        return {8'hFF, r[17:10], g[17:10], b[17:10]};
    endfunction

    // Advance the tracked state by one accepted pixel and return the pixel it gives.
    task automatic convert_pixel(input logic [nv2a_pkg::PIX_W-1:0] luma,
                                 input logic [nv2a_pkg::PIX_W-1:0] cv,
                                 input logic [nv2a_pkg::PIX_W-1:0] cu,
                                 output logic [nv2a_pkg::ARGB_W-1:0] argb);
        int unsigned w;
        int unsigned next_col;
        // Even column: latch the incoming pair; odd column: keep the held one.
        if (model_column[0] == 1'b0) begin
            model_held_v = cv;
            model_held_u = cu;
        end
        argb = yuv_to_argb(luma, model_held_v, model_held_u);
        // Width zero acts as one; widths past the maximum saturate.
        w = model_line_width;
        if (w == 0) begin
            w = 1;
        end
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        next_col = model_column + 1;
        model_column = (next_col >= w) ? 0 : next_col;
    endtask

    // Gap length: mostly none or short, now and then long; none in a quiet phase.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Byte with a bias toward the clamp and offset corners.
    function automatic logic [nv2a_pkg::PIX_W-1:0] pick_byte();
        logic [nv2a_pkg::PIX_W-1:0] corners [10];
        corners = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0) begin
            return corners[$urandom_range(0, 9)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one pixel beat and hold it until accepted, then record what it must give.
    // Push stays high on return so back-to-back beats need no second assignment.
    task automatic send_pixel(input logic [nv2a_pkg::PIX_W-1:0] luma,
                              input logic [nv2a_pkg::PIX_W-1:0] cv,
                              input logic [nv2a_pkg::PIX_W-1:0] cu,
                              input logic known,
                              input logic [nv2a_pkg::ARGB_W-1:0] known_argb);
        int unsigned gap;
        logic [nv2a_pkg::ARGB_W-1:0] predicted;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_luma     <= luma;
        i_chroma_v <= cv;
        i_chroma_u <= cu;
        do begin
            @(posedge i_clk);
        end while (full);
        convert_pixel(luma, cv, cu, predicted);
        expected_pixels.push_back(known ? known_argb : predicted);
    endtask

    // Drop push and wait until every expected pixel is out; each beat gives one
    // pixel, so the block is idle then.
    task automatic drain_pixels();
        push <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the line width while idle and track it.
    task automatic write_line_width(input logic [nv2a_pkg::LINE_WIDTH_W-1:0] w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        model_line_width = w;
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random phase: drain, set the width, then stream random pixels.
    task automatic run_phase(input logic [nv2a_pkg::LINE_WIDTH_W-1:0] w,
                             input int unsigned count, input logic quiet);
        drain_pixels();
        write_line_width(w);
        quiet_phase = quiet;
        repeat (count) begin
            send_pixel(pick_byte(), pick_byte(), pick_byte(), 1'b0, '0);
        end
    endtask

    // Result side: check each popped beat against the oldest expectation, and
    // stall pop at random.
    always @(posedge i_clk) begin
        logic [nv2a_pkg::ARGB_W-1:0] want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("unexpected pixel %h with nothing pending", o_argb_pixel);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_argb_pixel !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("argb_pixel mismatch: expected %h, got %h",
                                     want, o_argb_pixel);
                        end
                    end
                end
            end
            if (pop_hold > 0) begin
                pop_hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    pop_hold = pick_gap();
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run at the reset width, so reset values are checked too.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_pixel(DIRECTED_ROWS[i].luma, DIRECTED_ROWS[i].chroma_v,
                       DIRECTED_ROWS[i].chroma_u, DIRECTED_ROWS[i].known,
                       DIRECTED_ROWS[i].argb);
        end

        // Extreme widths first; a mid-row change happens at each phase boundary.
        run_phase(13'd1, 60, 1'b0);
        run_phase(13'd0, 60, 1'b1);
        run_phase(13'd2, 70, 1'b0);
        run_phase(13'd3, 70, 1'b0);
        // Widths past the maximum act as the maximum.
        run_phase(13'd8191, 60, 1'b0);
        run_phase(13'd4096, 60, 1'b1);
        run_phase(13'd4095, 60, 1'b0);
        run_phase(13'd5, 70, 1'b0);
        repeat (4) begin
            if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(0, 8191);
            end else begin
                w = $urandom_range(1, 40);
            end
            run_phase(w[nv2a_pkg::LINE_WIDTH_W-1:0], 80, ($urandom_range(0, 3) == 0));
        end
        run_phase(nv2a_pkg::LINE_WIDTH_RESET, 80, 1'b0);

        drain_pixels();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
